[hw/rtl/tgapsd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgapsd_pkg
// Shared types and constants for the Targa pixel stream decoder.
// ----------------------------------------------------------------------------
package tgapsd_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
	} byte_item_t;

	typedef struct packed {
		logic       valid;
		byte_item_t item;
	} stage_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        error_code;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [7:0]  repeat_res;
		logic        last_pixel;
	} result_t;

	localparam logic [1:0] KIND_PIXEL   = 2'd0;
	localparam logic [1:0] KIND_HDR_OK  = 2'd1;
	localparam logic [1:0] KIND_HDR_BAD = 2'd2;

	localparam logic ERR_TYPE   = 1'b0;
	localparam logic ERR_FORMAT = 1'b1;

	localparam logic [7:0] TYPE_RAW     = 8'd2;
	localparam logic [7:0] TYPE_RLE     = 8'd10;
	localparam logic [7:0] BPP_24       = 8'd24;
	localparam logic [7:0] BPP_32       = 8'd32;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	localparam logic [4:0] HDR_ID_LEN    = 5'd0;
	localparam logic [4:0] HDR_CMAP_TYPE = 5'd1;
	localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
	localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
	localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
	localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
	localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
	localparam logic [4:0] HDR_BPP       = 5'd16;
	localparam logic [4:0] HDR_DESC      = 5'd17;

	localparam int SCR_BAD_TYPE = 0;
	localparam int SCR_CMAP     = 1;
	localparam int SCR_BAD_BPP  = 2;

endpackage
`default_nettype wire

[hw/rtl/tgapsd_byte_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgapsd_byte_if
// Byte stream channel: one file byte and its start-of-file mark per transaction.
// ----------------------------------------------------------------------------
interface tgapsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_file;

	modport source (output valid, output data_byte, output start_of_file, input ready);
	modport sink (input valid, input data_byte, input start_of_file, output ready);
endinterface
`default_nettype wire

[hw/rtl/tgapsd_result_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgapsd_result_if
// Result channel: header status or one pixel run per transaction.
// ----------------------------------------------------------------------------
interface tgapsd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic        error_code;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [7:0]  repeat_res;
	logic        last_pixel;

	modport source (output valid, output kind, output error_code, output image_width,
		output image_height, output red, output green, output blue, output alpha,
		output repeat_res, output last_pixel, input ready);
	modport sink (input valid, input kind, input error_code, input image_width,
		input image_height, input red, input green, input blue, input alpha,
		input repeat_res, input last_pixel, output ready);
endinterface
`default_nettype wire

[hw/rtl/tga_pixel_stream_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder
// Targa type 2 and type 10 decoder that turns a file byte stream into header
// status and RGBA pixel runs.
// ----------------------------------------------------------------------------
// A result is registered when the decoder takes the byte that completes it.
// Throughput: one byte per cycle (input and result registers) while results are taken.
// A pixel takes three or four bytes, plus one packet byte per run-length packet.
// Reset clears the decoder to idle; bytes before a start-of-file mark are dropped.
module tga_pixel_stream_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	tgapsd_byte_if.sink      stream,
	tgapsd_result_if.source  result
);
	import tgapsd_pkg::*;

	stage_t s1;
	logic   take;

	tgapsd_in_stage u_in_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.take   (take),
		.s1     (s1)
	);

	tgapsd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.s1     (s1),
		.take   (take),
		.result (result)
	);
endmodule
`default_nettype wire

[hw/rtl/tgapsd_in_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgapsd_in_stage
// Input register that holds one byte until the decoder takes it.
// ----------------------------------------------------------------------------
module tgapsd_in_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	tgapsd_byte_if.sink          stream,
	input  wire logic            take,
	output tgapsd_pkg::stage_t   s1
);
	import tgapsd_pkg::*;

	logic       valid_s1;
	byte_item_t item_s1;

	assign stream.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			item_s1.data_byte     <= stream.data_byte;
			item_s1.start_of_file <= stream.start_of_file;
		end
	end

	assign s1.valid = valid_s1;
	assign s1.item  = item_s1;
endmodule
`default_nettype wire

[hw/rtl/tgapsd_decode.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgapsd_decode
// Header parser, ID skip and pixel packet decoder with the result register.
// ----------------------------------------------------------------------------
module tgapsd_decode (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tgapsd_pkg::stage_t s1,
	output logic                 take,
	tgapsd_result_if.source      result
);
	import tgapsd_pkg::*;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_IDSKIP = 3'd2;
	localparam logic [2:0] PH_PIXELS = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	logic [2:0]  phase_q, phase_d;
	logic [4:0]  idx_q, idx_d;
	logic        is_rle_q, is_rle_d;
	logic        four_q, four_d;
	logic [7:0]  id_left_q, id_left_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic [31:0] area_q;
	logic [31:0] pix_left_q, pix_left_d;
	logic [7:0]  pkt_left_q, pkt_left_d;
	logic        run_q, run_d;
	logic [1:0]  cidx_q, cidx_d;
	logic [7:0]  blue_q, blue_d;
	logic [7:0]  green_q, green_d;
	logic [7:0]  red_q, red_d;
	logic [2:0]  scr_q, scr_d;

	logic        out_valid_q;
	result_t     res_q;
	result_t     res_d;
	logic        res_vld;

	logic [7:0]  b;
	logic [2:0]  e_phase;
	logic [4:0]  e_idx;
	logic [2:0]  e_scr;
	logic [7:0]  pix_rep;
	logic [7:0]  pix_clip;
	logic [31:0] pix_rest;
	logic        pix_last_byte;
	logic [7:0]  id_dec;

	assign take = s1.valid && (!out_valid_q || result.ready);
	assign b    = s1.item.data_byte;

	assign e_phase = s1.item.start_of_file ? PH_HEADER : phase_q;
	assign e_idx   = s1.item.start_of_file ? 5'd0 : idx_q;
	assign e_scr   = s1.item.start_of_file ? 3'd0 : scr_q;

	assign pix_rep       = (is_rle_q && run_q) ? pkt_left_q : 8'd1;
	assign pix_clip      = ({24'd0, pix_rep} > pix_left_q) ? pix_left_q[7:0] : pix_rep;
	assign pix_rest      = pix_left_q - {24'd0, pix_clip};
	assign pix_last_byte = (cidx_q == (four_q ? 2'd3 : 2'd2));
	assign id_dec        = id_left_q - 8'd1;

	always_comb begin
		phase_d    = e_phase;
		idx_d      = e_idx;
		is_rle_d   = is_rle_q;
		four_d     = four_q;
		id_left_d  = id_left_q;
		width_d    = width_q;
		height_d   = height_q;
		pix_left_d = pix_left_q;
		pkt_left_d = pkt_left_q;
		run_d      = run_q;
		cidx_d     = cidx_q;
		blue_d     = blue_q;
		green_d    = green_q;
		red_d      = red_q;
		scr_d      = e_scr;
		res_vld    = 1'b0;
		res_d      = '0;
		case (e_phase)
			PH_HEADER: begin
				idx_d = e_idx + 5'd1;
				case (e_idx)
					HDR_ID_LEN: id_left_d = b;
					HDR_CMAP_TYPE: begin
						if (b != 8'd0) scr_d[SCR_CMAP] = 1'b1;
					end
					HDR_IMG_TYPE: begin
						if (b == TYPE_RAW) is_rle_d = 1'b0;
						else if (b == TYPE_RLE) is_rle_d = 1'b1;
						else scr_d[SCR_BAD_TYPE] = 1'b1;
					end
					HDR_WIDTH_LO: width_d[7:0] = b;
					HDR_WIDTH_HI: width_d[15:8] = b;
					HDR_HEIGHT_LO: height_d[7:0] = b;
					HDR_HEIGHT_HI: height_d[15:8] = b;
					HDR_BPP: begin
						if (b == BPP_24) four_d = 1'b0;
						else if (b == BPP_32) four_d = 1'b1;
						else scr_d[SCR_BAD_BPP] = 1'b1;
					end
					HDR_DESC: begin
						res_vld = 1'b1;
						if (e_scr[SCR_BAD_TYPE]) begin
							res_d.kind       = KIND_HDR_BAD;
							res_d.error_code = ERR_TYPE;
							phase_d          = PH_DONE;
						end else if (e_scr[SCR_CMAP] || e_scr[SCR_BAD_BPP]) begin
							res_d.kind       = KIND_HDR_BAD;
							res_d.error_code = ERR_FORMAT;
							phase_d          = PH_DONE;
						end else begin
							res_d.kind         = KIND_HDR_OK;
							res_d.image_width  = width_q;
							res_d.image_height = height_q;
							if (width_q == 16'd0 || height_q == 16'd0) begin
								res_d.last_pixel = 1'b1;
								phase_d          = PH_DONE;
							end else if (id_left_q != 8'd0) begin
								phase_d = PH_IDSKIP;
							end else begin
								pix_left_d = area_q;
								pkt_left_d = 8'd0;
								run_d      = 1'b0;
								cidx_d     = 2'd0;
								phase_d    = PH_PIXELS;
							end
						end
					end
					default: ;
				endcase
			end
			PH_IDSKIP: begin
				id_left_d = id_dec;
				if (id_dec == 8'd0) begin
					pix_left_d = area_q;
					pkt_left_d = 8'd0;
					run_d      = 1'b0;
					cidx_d     = 2'd0;
					phase_d    = PH_PIXELS;
				end
			end
			PH_PIXELS: begin
				if (is_rle_q && pkt_left_q == 8'd0) begin
					pkt_left_d = {1'b0, b[6:0]} + 8'd1;
					run_d      = b[7];
					cidx_d     = 2'd0;
				end else begin
					case (cidx_q)
						2'd0: blue_d = b;
						2'd1: green_d = b;
						2'd2: red_d = b;
						default: ;
					endcase
					if (!pix_last_byte) begin
						cidx_d = cidx_q + 2'd1;
					end else begin
						cidx_d = 2'd0;
						if (is_rle_q) begin
							pkt_left_d = run_q ? 8'd0 : pkt_left_q - 8'd1;
						end
						pix_left_d       = pix_rest;
						res_vld          = 1'b1;
						res_d.kind       = KIND_PIXEL;
						res_d.red        = (cidx_q == 2'd2) ? b : red_q;
						res_d.green      = green_q;
						res_d.blue       = blue_q;
						res_d.alpha      = four_q ? b : ALPHA_OPAQUE;
						res_d.repeat_res = pix_clip;
						if (pix_rest == 32'd0) begin
							res_d.last_pixel = 1'b1;
							phase_d          = PH_DONE;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			idx_q       <= '0;
			is_rle_q    <= 1'b0;
			four_q      <= 1'b0;
			id_left_q   <= '0;
			width_q     <= '0;
			height_q    <= '0;
			pix_left_q  <= '0;
			pkt_left_q  <= '0;
			run_q       <= 1'b0;
			cidx_q      <= '0;
			blue_q      <= '0;
			green_q     <= '0;
			red_q       <= '0;
			scr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q    <= phase_d;
				idx_q      <= idx_d;
				is_rle_q   <= is_rle_d;
				four_q     <= four_d;
				id_left_q  <= id_left_d;
				width_q    <= width_d;
				height_q   <= height_d;
				pix_left_q <= pix_left_d;
				pkt_left_q <= pkt_left_d;
				run_q      <= run_d;
				cidx_q     <= cidx_d;
				blue_q     <= blue_d;
				green_q    <= green_d;
				red_q      <= red_d;
				scr_q      <= scr_d;
			end
			if (take && res_vld) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The pixel count is formed from the registered size, which is settled two
	// header bytes before it is needed.
	always_ff @(posedge clk) begin
		area_q <= {16'd0, width_q} * {16'd0, height_q};
		if (take && res_vld) begin
			res_q <= res_d;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.kind         = res_q.kind;
	assign result.error_code   = res_q.error_code;
	assign result.image_width  = res_q.image_width;
	assign result.image_height = res_q.image_height;
	assign result.red          = res_q.red;
	assign result.green        = res_q.green;
	assign result.blue         = res_q.blue;
	assign result.alpha        = res_q.alpha;
	assign result.repeat_res   = res_q.repeat_res;
	assign result.last_pixel   = res_q.last_pixel;

	a_empty_image_done: assert property (@(posedge clk) disable iff (!arst_n)
		take && res_vld && res_d.kind == KIND_HDR_OK && res_d.last_pixel |=> phase_q == PH_DONE)
		else $error("empty image did not end decoding");

	a_pixels_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PIXELS |-> pix_left_q != 32'd0)
		else $error("pixel phase with no pixels left");

	a_pixels_left_falls: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PIXELS && $past(phase_q) == PH_PIXELS |-> pix_left_q <= $past(pix_left_q))
		else $error("pixel count grew during the image");

	a_packet_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_left_q <= 8'd128)
		else $error("packet count out of range");
endmodule
`default_nettype wire
